[src/mlp_inference_and_training_core_assert.svh]
// Assertion macros for the perceptron core.
// Used by the top level only; no other dependencies.
`ifndef MLP_INFERENCE_AND_TRAINING_CORE_ASSERT_SVH
`define MLP_INFERENCE_AND_TRAINING_CORE_ASSERT_SVH

// same-cycle implication
`define MLP_AST_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("mlp core: implication check failed");

// next-cycle implication
`define MLP_AST_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("mlp core: next-cycle check failed");

`endif

[src/mlp_pkg.sv]
// Shared types, codes and arithmetic helpers for the perceptron core.
// No dependencies.
package mlp_pkg;

  // default network shape
  localparam int NUM_INPUTS_DEF  = 16;
  localparam int NUM_HIDDEN_DEF  = 8;
  localparam int NUM_OUTPUTS_DEF = 4;

  localparam logic [15:0] STEP_SIZE_RST = 16'd655;

  // func codes
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_FEATURE = 2'd1;
  localparam logic [1:0] FUNC_TARGET  = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE,
    S_HB_RD, S_HB_LD, S_H_RD, S_H_MUL, S_H_ACC, S_H_END,
    S_OB_RD, S_OB_LD, S_O_RD, S_O_MUL, S_O_ACC, S_O_END,
    S_EMIT,
    S_E_SLOPE, S_E_DIFF, S_E_END,
    S_D_CLR, S_D_RD, S_D_MUL, S_D_ACC, S_D_END,
    S_WO_RD, S_WO_LR, S_WO_WR,
    S_WI_RD, S_WI_LR, S_WI_WR,
    S_BO_RD, S_BO_WR,
    S_BH_RD, S_BH_WR
  } state_t;

  typedef enum logic [1:0] {WR_INPUT, WR_UPD_W, WR_UPD_B} wr_sel_t;

  typedef enum logic [3:0] {
    MUL_X_W, MUL_ACT_W, MUL_SLOPE, MUL_DIFF, MUL_E_W,
    MUL_E_ACT, MUL_D_X, MUL_LR, MUL_E_LR, MUL_D_LR
  } mul_sel_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_BIAS, ACC_ZERO, ACC_ADD} acc_op_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_FEAT, ST_TGT, ST_ACT, ST_PROB, ST_OERR, ST_HERR
  } st_op_t;

  // controller to datapath command
  typedef struct packed {
    logic     mem_re;
    logic     mem_we;
    wr_sel_t  wr_sel;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    st_op_t   st_op;
    logic     out_load;
  } dp_cmd_t;

  // divide by 2^s, rounding half up
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // piecewise-linear sigmoid, Q4.12 in, Q1.12 out
  function automatic logic [12:0] sigmoid_q12(input logic signed [15:0] z);
    logic [16:0] a;
    logic [16:0] y;
    a = z[15] ? 17'(-(17'(z))) : 17'(z);
    if (a >= 17'd20480) y = 17'd4096;
    else if (a >= 17'd9728) y = (a >> 5) + 17'd3456;
    else if (a >= 17'd4096) y = (a >> 3) + 17'd2560;
    else y = (a >> 2) + 17'd2048;
    if (z[15]) y = 17'd4096 - y;
    return y[12:0];
  endfunction

endpackage

[src/mlp_ctrl.sv]
// Sequencer for the perceptron core: input handshake, forward and
// training passes, result emission. Depends on mlp_pkg.
module mlp_ctrl #(
  parameter int NI = 16,
  parameter int NH = 8,
  parameter int NO = 4,
  parameter int FW = 4,
  parameter int HW = 3,
  parameter int OW = 2,
  parameter int AW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_index,
  input  logic               in_last,
  output logic               out_tvalid,
  input  logic               out_tready,
  output mlp_pkg::dp_cmd_t   cmd,
  output logic [AW-1:0]      mem_addr,
  output logic [FW-1:0]      f_idx,
  output logic [HW-1:0]      h_idx,
  output logic [OW-1:0]      o_idx
);
  import mlp_pkg::*;

  localparam int WHO_BASE = NI * NH;
  localparam int BH_BASE  = WHO_BASE + NH * NO;
  localparam int BO_BASE  = BH_BASE + NH;
  localparam int MAP_END  = BO_BASE + NO;
  localparam logic [FW-1:0] F_LAST = FW'(NI - 1);
  localparam logic [HW-1:0] H_LAST = HW'(NH - 1);
  localparam logic [OW-1:0] O_LAST = OW'(NO - 1);

  state_t        state_r, state_nxt;
  logic [FW-1:0] f_r, f_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic          train_r, train_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] a_wih, a_who, a_bh, a_bo;

  assign a_wih = AW'(NH * int'(f_r) + int'(h_r));
  assign a_who = AW'(WHO_BASE + NO * int'(h_r) + int'(o_r));
  assign a_bh  = AW'(BH_BASE + int'(h_r));
  assign a_bo  = AW'(BO_BASE + int'(o_r));

  assign f_idx      = f_r;
  assign h_idx      = h_r;
  assign o_idx      = o_r;
  assign out_tvalid = out_valid_r;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      f_r         <= '0;
      h_r         <= '0;
      o_r         <= '0;
      train_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      f_r         <= f_nxt;
      h_r         <= h_nxt;
      o_r         <= o_nxt;
      train_r     <= train_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    f_nxt     = f_r;
    h_nxt     = h_r;
    o_nxt     = o_r;
    train_nxt = train_r;
    in_tready = 1'b0;
    mem_addr  = '0;
    cmd       = '{mem_re: 1'b0, mem_we: 1'b0, wr_sel: WR_INPUT, mul_en: 1'b0,
                  mul_sel: MUL_X_W, acc_op: ACC_NONE, st_op: ST_NONE,
                  out_load: 1'b0};
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_func)
            FUNC_WRITE: begin
              if (int'(in_index) < MAP_END) begin
                cmd.mem_we = 1'b1;
                mem_addr   = AW'(in_index);
              end
            end
            FUNC_FEATURE: begin
              if (int'(in_index) < NI) cmd.st_op = ST_FEAT;
              if (in_last) begin
                train_nxt = 1'b0;
                f_nxt     = '0;
                h_nxt     = '0;
                state_nxt = S_HB_RD;
              end
            end
            FUNC_TARGET: begin
              if (int'(in_index) < NO) cmd.st_op = ST_TGT;
              if (in_last) begin
                train_nxt = 1'b1;
                f_nxt     = '0;
                h_nxt     = '0;
                state_nxt = S_HB_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // hidden layer
      S_HB_RD: begin
        cmd.mem_re = 1'b1;
        mem_addr   = a_bh;
        state_nxt  = S_HB_LD;
      end
      S_HB_LD: begin
        cmd.acc_op = ACC_BIAS;
        state_nxt  = S_H_RD;
      end
      S_H_RD: begin
        cmd.mem_re = 1'b1;
        mem_addr   = a_wih;
        state_nxt  = S_H_MUL;
      end
      S_H_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X_W;
        state_nxt   = S_H_ACC;
      end
      S_H_ACC: begin
        cmd.acc_op = ACC_ADD;
        if (f_r == F_LAST) begin
          f_nxt     = '0;
          state_nxt = S_H_END;
        end else begin
          f_nxt     = f_r + 1'b1;
          state_nxt = S_H_RD;
        end
      end
      S_H_END: begin
        cmd.st_op = ST_ACT;
        if (h_r == H_LAST) begin
          h_nxt     = '0;
          o_nxt     = '0;
          state_nxt = S_OB_RD;
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_HB_RD;
        end
      end
      // output layer
      S_OB_RD: begin
        cmd.mem_re = 1'b1;
        mem_addr   = a_bo;
        state_nxt  = S_OB_LD;
      end
      S_OB_LD: begin
        cmd.acc_op = ACC_BIAS;
        state_nxt  = S_O_RD;
      end
      S_O_RD: begin
        cmd.mem_re = 1'b1;
        mem_addr   = a_who;
        state_nxt  = S_O_MUL;
      end
      S_O_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACT_W;
        state_nxt   = S_O_ACC;
      end
      S_O_ACC: begin
        cmd.acc_op = ACC_ADD;
        if (h_r == H_LAST) begin
          h_nxt     = '0;
          state_nxt = S_O_END;
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_O_RD;
        end
      end
      S_O_END: begin
        cmd.st_op = ST_PROB;
        if (o_r == O_LAST) begin
          o_nxt     = '0;
          state_nxt = train_r ? S_E_SLOPE : S_EMIT;
        end else begin
          o_nxt     = o_r + 1'b1;
          state_nxt = S_OB_RD;
        end
      end
      // results out, one per transfer slot
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          if (o_r == O_LAST) begin
            o_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            o_nxt = o_r + 1'b1;
          end
        end
      end
      // output error terms
      S_E_SLOPE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SLOPE;
        state_nxt   = S_E_DIFF;
      end
      S_E_DIFF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DIFF;
        state_nxt   = S_E_END;
      end
      S_E_END: begin
        cmd.st_op = ST_OERR;
        if (o_r == O_LAST) begin
          o_nxt     = '0;
          h_nxt     = '0;
          state_nxt = S_D_CLR;
        end else begin
          o_nxt     = o_r + 1'b1;
          state_nxt = S_E_SLOPE;
        end
      end
      // hidden error terms, old output weights
      S_D_CLR: begin
        cmd.acc_op = ACC_ZERO;
        state_nxt  = S_D_RD;
      end
      S_D_RD: begin
        cmd.mem_re = 1'b1;
        mem_addr   = a_who;
        state_nxt  = S_D_MUL;
      end
      S_D_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_E_W;
        state_nxt   = S_D_ACC;
      end
      S_D_ACC: begin
        cmd.acc_op = ACC_ADD;
        if (o_r == O_LAST) begin
          o_nxt     = '0;
          state_nxt = S_D_END;
        end else begin
          o_nxt     = o_r + 1'b1;
          state_nxt = S_D_RD;
        end
      end
      S_D_END: begin
        cmd.st_op = ST_HERR;
        if (h_r == H_LAST) begin
          h_nxt     = '0;
          o_nxt     = '0;
          state_nxt = S_WO_RD;
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_D_CLR;
        end
      end
      // output weight update
      S_WO_RD: begin
        cmd.mem_re  = 1'b1;
        mem_addr    = a_who;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_E_ACT;
        state_nxt   = S_WO_LR;
      end
      S_WO_LR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LR;
        state_nxt   = S_WO_WR;
      end
      S_WO_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wr_sel = WR_UPD_W;
        mem_addr   = a_who;
        state_nxt  = S_WO_RD;
        if (o_r == O_LAST) begin
          o_nxt = '0;
          if (h_r == H_LAST) begin
            h_nxt     = '0;
            f_nxt     = '0;
            state_nxt = S_WI_RD;
          end else begin
            h_nxt = h_r + 1'b1;
          end
        end else begin
          o_nxt = o_r + 1'b1;
        end
      end
      // input weight update
      S_WI_RD: begin
        cmd.mem_re  = 1'b1;
        mem_addr    = a_wih;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D_X;
        state_nxt   = S_WI_LR;
      end
      S_WI_LR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LR;
        state_nxt   = S_WI_WR;
      end
      S_WI_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wr_sel = WR_UPD_W;
        mem_addr   = a_wih;
        state_nxt  = S_WI_RD;
        if (h_r == H_LAST) begin
          h_nxt = '0;
          if (f_r == F_LAST) begin
            f_nxt     = '0;
            o_nxt     = '0;
            state_nxt = S_BO_RD;
          end else begin
            f_nxt = f_r + 1'b1;
          end
        end else begin
          h_nxt = h_r + 1'b1;
        end
      end
      // bias updates
      S_BO_RD: begin
        cmd.mem_re  = 1'b1;
        mem_addr    = a_bo;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_E_LR;
        state_nxt   = S_BO_WR;
      end
      S_BO_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wr_sel = WR_UPD_B;
        mem_addr   = a_bo;
        if (o_r == O_LAST) begin
          o_nxt     = '0;
          h_nxt     = '0;
          state_nxt = S_BH_RD;
        end else begin
          o_nxt     = o_r + 1'b1;
          state_nxt = S_BO_RD;
        end
      end
      S_BH_RD: begin
        cmd.mem_re  = 1'b1;
        mem_addr    = a_bh;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D_LR;
        state_nxt   = S_BH_WR;
      end
      S_BH_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wr_sel = WR_UPD_B;
        mem_addr   = a_bh;
        if (h_r == H_LAST) begin
          h_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_BH_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[src/mlp_datapath.sv]
// Datapath of the perceptron core: parameter memory, stores, one shared
// multiplier, accumulator, output register. Depends on mlp_pkg.
module mlp_datapath #(
  parameter int NI = 16,
  parameter int NH = 8,
  parameter int NO = 4,
  parameter int FW = 4,
  parameter int HW = 3,
  parameter int OW = 2,
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic [7:0]        in_index,
  input  logic [15:0]       in_value,
  input  mlp_pkg::dp_cmd_t  cmd,
  input  logic [AW-1:0]     mem_addr,
  input  logic [FW-1:0]     f_idx,
  input  logic [HW-1:0]     h_idx,
  input  logic [OW-1:0]     o_idx,
  output logic [1:0]        out_index,
  output logic [12:0]       out_prob,
  output logic              out_last
);
  import mlp_pkg::*;

  localparam int MAP_END = NI * NH + NH * NO + NH + NO;
  localparam logic [OW-1:0] O_LAST = OW'(NO - 1);

  logic [15:0]        lr_r;
  logic signed [15:0] mem [MAP_END];
  logic [MAP_END-1:0] valid_r;
  logic signed [15:0] rd_r;
  logic signed [15:0] x_r    [NI];
  logic signed [15:0] tgt_r  [NO];
  logic signed [15:0] act_r  [NH];
  logic [12:0]        prob_r [NO];
  logic signed [15:0] oerr_r [NO];
  logic signed [15:0] herr_r [NH];
  logic signed [58:0] prod_r;
  logic signed [47:0] acc_r;
  logic [1:0]         out_index_r;
  logic [12:0]        out_prob_r;
  logic               out_last_r;

  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [16:0] diff;
  logic signed [13:0] slope_b;
  logic signed [15:0] wdata;
  logic signed [15:0] acc_q12;

  // learning rate register
  always_ff @(posedge clk) begin
    if (!rst_n) lr_r <= STEP_SIZE_RST;
    else if (cfg_we) lr_r <= cfg_wdata;
  end

  // memory write data
  always_comb begin
    case (cmd.wr_sel)
      WR_UPD_W: wdata = sat16(64'(rd_r) + rnd_shift(64'(prod_r), 28));
      WR_UPD_B: wdata = sat16(64'(rd_r) + rnd_shift(64'(prod_r), 16));
      default:  wdata = signed'(in_value);
    endcase
  end

  // valid bits stand for the zero reset of the weights
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (cmd.mem_we) valid_r[mem_addr] <= 1'b1;
  end

  // parameter memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[mem_addr] <= wdata;
    if (cmd.mem_re) rd_r <= valid_r[mem_addr] ? mem[mem_addr] : 16'sd0;
  end

  // multiplier operand select
  assign diff    = 17'(tgt_r[o_idx]) - signed'({4'b0, prob_r[o_idx]});
  assign slope_b = 14'sd4096 - signed'({1'b0, prob_r[o_idx]});

  always_comb begin
    case (cmd.mul_sel)
      MUL_X_W:   begin mul_a = 33'(x_r[f_idx]);    mul_b = 26'(rd_r);             end
      MUL_ACT_W: begin mul_a = 33'(act_r[h_idx]);  mul_b = 26'(rd_r);             end
      MUL_SLOPE: begin
        mul_a = 33'(signed'({1'b0, prob_r[o_idx]}));
        mul_b = 26'(slope_b);
      end
      MUL_DIFF:  begin mul_a = prod_r[32:0];        mul_b = 26'(diff);             end
      MUL_E_W:   begin mul_a = 33'(oerr_r[o_idx]); mul_b = 26'(rd_r);             end
      MUL_E_ACT: begin mul_a = 33'(oerr_r[o_idx]); mul_b = 26'(act_r[h_idx]);     end
      MUL_D_X:   begin mul_a = 33'(herr_r[h_idx]); mul_b = 26'(x_r[f_idx]);       end
      MUL_LR:    begin mul_a = prod_r[32:0]; mul_b = 26'(signed'({1'b0, lr_r})); end
      MUL_E_LR:  begin
        mul_a = 33'(oerr_r[o_idx]);
        mul_b = 26'(signed'({1'b0, lr_r}));
      end
      MUL_D_LR:  begin
        mul_a = 33'(herr_r[h_idx]);
        mul_b = 26'(signed'({1'b0, lr_r}));
      end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    case (cmd.acc_op)
      ACC_BIAS: acc_r <= 48'(rd_r) <<< 12;
      ACC_ZERO: acc_r <= '0;
      ACC_ADD:  acc_r <= acc_r + signed'(prod_r[47:0]);
      default:  ;
    endcase
  end

  assign acc_q12 = sat16(rnd_shift(64'(acc_r), 12));

  // vector stores
  always_ff @(posedge clk) begin
    case (cmd.st_op)
      ST_FEAT: x_r[in_index[FW-1:0]]   <= signed'(in_value);
      ST_TGT:  tgt_r[in_index[OW-1:0]] <= signed'(in_value);
      ST_ACT:  act_r[h_idx]  <= acc_q12[15] ? 16'sd0 : acc_q12;
      ST_PROB: prob_r[o_idx] <= sigmoid_q12(acc_q12);
      ST_OERR: oerr_r[o_idx] <= sat16(rnd_shift(64'(prod_r), 24));
      ST_HERR: herr_r[h_idx] <= (act_r[h_idx] > 16'sd0) ? acc_q12 : 16'sd0;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_prob_r  <= prob_r[o_idx];
      out_index_r <= 2'(o_idx);
      out_last_r  <= (o_idx == O_LAST);
    end
  end

  assign out_index = out_index_r;
  assign out_prob  = out_prob_r;
  assign out_last  = out_last_r;

endmodule

[src/mlp_inference_and_training_core.sv]
// Top level of the perceptron core: sequencer plus datapath.
// Depends on mlp_pkg, mlp_ctrl, mlp_datapath and the assertion header.
//
//  channel | dir | tdata                         | tuser       | tlast
//  in_     | in  | [7:0] index, [23:8] value     | [1:0] func  | in_last
//  out_    | out | [12:0] probability, rest zero | [1:0] index | out_last
//  cfg_    | in  | cfg_wdata [15:0] step_size    | -           | -
//
// Writes and non-final feature/target items are accepted without leaving idle.
// A final feature runs the forward pass on the single multiply-accumulate
// unit, then emits NO results.
// A final target runs the same forward pass, then the error terms and the
// weight and bias read-modify-write, and emits no results.
// Reset clears the weight valid bits at once; no clearing pass.
// Result stalls hold the emit state; in_tready is high only when idle.
`include "mlp_inference_and_training_core_assert.svh"

module mlp_inference_and_training_core #(
  parameter int NUM_INPUTS  = mlp_pkg::NUM_INPUTS_DEF,
  parameter int NUM_HIDDEN  = mlp_pkg::NUM_HIDDEN_DEF,
  parameter int NUM_OUTPUTS = mlp_pkg::NUM_OUTPUTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // step_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [7:0] index, [23:8] value
  input  logic [1:0]  in_tuser,    // [1:0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [12:0] probability, [15:13] zero
  output logic [1:0]  out_tuser,   // [1:0] out_index
  output logic        out_tlast
);
  import mlp_pkg::*;

  localparam int FW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int HW = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int MAP_END = NUM_INPUTS * NUM_HIDDEN + NUM_HIDDEN * NUM_OUTPUTS
                           + NUM_HIDDEN + NUM_OUTPUTS;
  localparam int AW = $clog2(MAP_END);

  dp_cmd_t       cmd;
  logic [AW-1:0] mem_addr;
  logic [FW-1:0] f_idx;
  logic [HW-1:0] h_idx;
  logic [OW-1:0] o_idx;
  logic [12:0]   out_prob;

  mlp_ctrl #(
    .NI(NUM_INPUTS), .NH(NUM_HIDDEN), .NO(NUM_OUTPUTS),
    .FW(FW), .HW(HW), .OW(OW), .AW(AW)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_func(in_tuser), .in_index(in_tdata[7:0]), .in_last(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .mem_addr(mem_addr),
    .f_idx(f_idx), .h_idx(h_idx), .o_idx(o_idx)
  );

  mlp_datapath #(
    .NI(NUM_INPUTS), .NH(NUM_HIDDEN), .NO(NUM_OUTPUTS),
    .FW(FW), .HW(HW), .OW(OW), .AW(AW)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_index(in_tdata[7:0]), .in_value(in_tdata[23:8]),
    .cmd(cmd), .mem_addr(mem_addr),
    .f_idx(f_idx), .h_idx(h_idx), .o_idx(o_idx),
    .out_index(out_tuser), .out_prob(out_prob), .out_last(out_tlast)
  );

  assign out_tdata = {3'b000, out_prob};

  // a final feature transfer starts a pass and drops ready
  `MLP_AST_NEXT(a_pass_busy, clk, rst_n,
    in_tvalid && in_tready && (in_tuser == FUNC_FEATURE) && in_tlast, !in_tready)
  // the single memory port never reads and writes together
  `MLP_AST_IMP(a_mem_port, clk, rst_n, cmd.mem_we, !cmd.mem_re)
  // results are loaded only while a pass is running
  `MLP_AST_IMP(a_emit_busy, clk, rst_n, cmd.out_load, !in_tready)

endmodule
